[hw/rtl/gbn_pkg.sv]
// Shared types, codes and constants of the Go-Back-N sender.
package gbn_pkg;

   localparam int unsigned DEFAULT_WINDOW = 16;
   localparam int unsigned PAYLOAD_BYTES = 20;
   localparam int unsigned CHECK_MODULUS = 99991;
   localparam logic [15:0] DEFAULT_TIMEOUT = 16'd10;

   typedef enum logic [1:0] {
      OP_SEND = 2'd0,
      OP_ACK  = 2'd1,
      OP_TICK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_SENT    = 3'd0,
      KIND_REFUSED = 3'd1,
      KIND_ACK_OK  = 3'd2,
      KIND_ACK_BAD = 3'd3,
      KIND_RETX    = 3'd4
   } kind_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [63:0]        payload_low;
      logic [63:0]        payload_middle;
      logic [31:0]        payload_high;
      logic signed [31:0] ack_sequence_field;
      logic signed [31:0] ack_number;
      logic signed [31:0] ack_checksum;
   } req_type;

   typedef struct packed {
      logic [2:0]         result_kind;
      logic [31:0]        packet_sequence;
      logic signed [31:0] packet_check;
      logic [63:0]        out_payload_low;
      logic [63:0]        out_payload_middle;
      logic [31:0]        out_payload_high;
      logic [31:0]        window_start;
      logic               last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_FOLD_SEQ,
      CMD_FOLD_ACK,
      CMD_CAPTURE,
      CMD_BYTE,
      CMD_SEND,
      CMD_REFUSE,
      CMD_ADVANCE,
      CMD_ACK_EMIT,
      CMD_TICK,
      CMD_READ,
      CMD_RETX
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   window_full;
      logic   fold_busy;
      logic   bytes_last;
      logic   ack_good;
      logic   advance;
      logic   advance_more;
      logic   expire;
      logic   retx_last;
      logic   out_free;
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_REFUSE,
      S_FOLD1,
      S_FOLD2,
      S_BYTES,
      S_FINISH,
      S_ADVANCE,
      S_READ,
      S_RETX
   } state_type;

endpackage

[hw/rtl/go_back_n_sender.sv]
// Go-Back-N sender top level: controller and datapath.
// A send or an ack runs two checksum folds, a capture step and 20 byte steps, then loads
// its result once the result register is free; an ack that moves the base steps it first.
// A refused send loads a refusal result; a tick that does not expire only updates the timer;
// an expiring tick gives retransmissions (store read, then result), up to WINDOW results.
// Synchronous active-high reset clears the sequence numbers and timer and sets the timeout to 10.
module go_back_n_sender #(
   parameter int unsigned WINDOW = gbn_pkg::DEFAULT_WINDOW
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gbn_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gbn_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic [15:0]      csr_write_data
);

   gbn_pkg::cmd_type    cmd;
   gbn_pkg::status_type status;

   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gbn_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload)
   );

endmodule

[hw/rtl/gbn_fold.sv]
// Checksum fold unit: sign(s) * (|s| mod 99991 + |s| div 99991) by reciprocal multiplication.
module gbn_fold (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [33:0] value,
   output logic               busy,
   output logic signed [33:0] result
);

   localparam logic [16:0] MODULUS = 17'(gbn_pkg::CHECK_MODULUS);
   localparam logic [15:0] RECIP = 16'((64'd1 << 32) / 64'(gbn_pkg::CHECK_MODULUS));
   localparam logic [18:0] MOD_1 = 19'(gbn_pkg::CHECK_MODULUS);
   localparam logic [18:0] MOD_2 = 19'(2 * gbn_pkg::CHECK_MODULUS);
   localparam logic [18:0] MOD_3 = 19'(3 * gbn_pkg::CHECK_MODULUS);

   logic        busy_ff, busy_in;
   logic [1:0]  step_ff, step_in;
   logic        neg_ff, neg_in;
   logic [32:0] mag_ff, mag_in;
   logic [16:0] quo_ff, quo_in;
   logic [18:0] rem_ff, rem_in;
   logic [17:0] total;

   // The estimated quotient is at most three below the true one, so the
   // remainder estimate stays under four moduli and three compares settle it.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = value[33];
         mag_in  = value[33] ? 33'(-value) : value[32:0];
      end else if (busy_ff) begin
         unique case (step_ff)
            2'd0: begin
               quo_in  = 17'((39'(mag_ff[32:10]) * 39'(RECIP)) >> 22);
               step_in = 2'd1;
            end
            2'd1: begin
               rem_in  = 19'({1'b0, mag_ff} - 34'(quo_ff) * 34'(MODULUS));
               step_in = 2'd2;
            end
            default: begin
               priority if (rem_ff >= MOD_3) begin
                  rem_in = rem_ff - MOD_3;
                  quo_in = quo_ff + 17'd3;
               end else if (rem_ff >= MOD_2) begin
                  rem_in = rem_ff - MOD_2;
                  quo_in = quo_ff + 17'd2;
               end else if (rem_ff >= MOD_1) begin
                  rem_in = rem_ff - MOD_1;
                  quo_in = quo_ff + 17'd1;
               end else begin
                  rem_in = rem_ff;
               end
               busy_in = 1'b0;
               step_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign total  = {1'b0, rem_ff[16:0]} + {1'b0, quo_ff};
   assign busy   = busy_ff;
   assign result = neg_ff ? -$signed({16'b0, total}) : $signed({16'b0, total});

endmodule

[hw/rtl/gbn_dp.sv]
// Datapath of the Go-Back-N sender: sequence state, packet store, checksum, timer and result register.
module gbn_dp #(
   parameter int unsigned WINDOW = gbn_pkg::DEFAULT_WINDOW
) (
   input  logic                clock,
   input  logic                reset,
   input  gbn_pkg::req_type    req_payload,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data,
   input  logic                rsp_ready,
   input  gbn_pkg::cmd_type    cmd,
   output gbn_pkg::status_type status,
   output logic                rsp_valid,
   output gbn_pkg::rsp_type    rsp_payload
);

   localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned CNT_W = $clog2(WINDOW + 1);
   localparam logic [31:0] WINDOW_32 = 32'(WINDOW);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic signed [33:0] MOD_S = 34'(gbn_pkg::CHECK_MODULUS);
   localparam logic signed [33:0] CORR_S = 34'(gbn_pkg::CHECK_MODULUS - 1);
   localparam logic [4:0] BYTE_LAST = 5'(gbn_pkg::PAYLOAD_BYTES - 1);

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] middle;
      logic [31:0] high;
      logic [31:0] check;
   } entry_type;

   function automatic logic [SLOT_W-1:0] slot_step(input logic [31:0] seq,
                                                   input logic [SLOT_W-1:0] slot);
      if (seq == '1 || slot == SLOT_LAST) begin
         return '0;
      end
      return slot + 1'b1;
   endfunction

   entry_type mem [WINDOW];
   entry_type rd_entry_ff;

   gbn_pkg::op_type    op_ff, op_in;
   logic [63:0]        low_ff, low_in, middle_ff, middle_in;
   logic [31:0]        high_ff, high_in;
   logic signed [31:0] seq_term_ff, seq_term_in, ack_term_ff, ack_term_in;
   logic signed [31:0] ack_check_ff, ack_check_in;
   logic [31:0]        nb_ff, nb_in;
   logic               in_window_ff, in_window_in;
   logic signed [33:0] s_ff, s_in;
   logic [4:0]         byte_ff, byte_in;

   logic [31:0]        base_ff, base_in, next_ff, next_in;
   logic [SLOT_W-1:0]  base_slot_ff, base_slot_in, next_slot_ff, next_slot_in;
   logic [SLOT_W-1:0]  retx_slot_ff, retx_slot_in;
   logic [CNT_W-1:0]   retx_cnt_ff, retx_cnt_in;
   logic               timer_run_ff, timer_run_in;
   logic [15:0]        timer_cnt_ff, timer_cnt_in, timeout_ff, timeout_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gbn_pkg::rsp_type   rsp_ff, rsp_in;

   logic               fold_start, fold_busy;
   logic signed [33:0] fold_value, fold_result;
   logic [31:0]        outstanding, req_nb, req_adv;
   logic [159:0]       payload_all;
   logic [7:0]         byte_val;
   logic signed [33:0] byte_sum;
   logic [15:0]        limit, tick_cnt;
   logic               tick_expire, ack_good, rsp_load, out_free;

   gbn_fold u_fold (
      .clock  (clock),
      .reset  (reset),
      .start  (fold_start),
      .value  (fold_value),
      .busy   (fold_busy),
      .result (fold_result)
   );

   assign outstanding = next_ff - base_ff;
   assign req_nb      = req_payload.ack_number + 32'd1;
   assign req_adv     = req_nb - base_ff;
   assign payload_all = {high_ff, middle_ff, low_ff};
   assign byte_val    = payload_all[byte_ff * 8 +: 8];
   assign byte_sum    = s_ff + $signed({26'b0, byte_val});
   assign limit       = (timeout_ff == '0) ? 16'd1 : timeout_ff;
   assign tick_cnt    = (timer_cnt_ff == '1) ? timer_cnt_ff : timer_cnt_ff + 16'd1;
   assign tick_expire = timer_run_ff && (tick_cnt >= limit);
   assign ack_good    = s_ff == 34'(ack_check_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      op_in        = op_ff;
      low_in       = low_ff;
      middle_in    = middle_ff;
      high_in      = high_ff;
      seq_term_in  = seq_term_ff;
      ack_term_in  = ack_term_ff;
      ack_check_in = ack_check_ff;
      nb_in        = nb_ff;
      in_window_in = in_window_ff;
      s_in         = s_ff;
      byte_in      = byte_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      base_slot_in = base_slot_ff;
      next_slot_in = next_slot_ff;
      retx_slot_in = retx_slot_ff;
      retx_cnt_in  = retx_cnt_ff;
      timer_run_in = timer_run_ff;
      timer_cnt_in = timer_cnt_ff;
      timeout_in   = csr_write_enable ? csr_write_data : timeout_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      fold_start   = 1'b0;
      fold_value   = 34'(seq_term_ff);

      unique case (cmd.code)
         gbn_pkg::CMD_LOAD: begin
            op_in        = gbn_pkg::op_type'(req_payload.operation);
            low_in       = req_payload.payload_low;
            middle_in    = req_payload.payload_middle;
            high_in      = req_payload.payload_high;
            ack_check_in = req_payload.ack_checksum;
            nb_in        = req_nb;
            in_window_in = (req_adv != '0) && (req_adv <= outstanding);
            if (req_payload.operation == gbn_pkg::OP_ACK) begin
               seq_term_in = req_payload.ack_sequence_field;
               ack_term_in = req_payload.ack_number;
            end else begin
               seq_term_in = $signed(next_ff);
               ack_term_in = '0;
            end
         end
         gbn_pkg::CMD_FOLD_SEQ: begin
            fold_start = 1'b1;
         end
         gbn_pkg::CMD_FOLD_ACK: begin
            fold_start = 1'b1;
            fold_value = fold_result + 34'(ack_term_ff);
         end
         gbn_pkg::CMD_CAPTURE: begin
            s_in    = fold_result;
            byte_in = '0;
         end
         gbn_pkg::CMD_BYTE: begin
            if (byte_sum >= MOD_S) begin
               s_in = byte_sum - CORR_S;
            end else if (byte_sum <= -MOD_S) begin
               s_in = byte_sum + CORR_S;
            end else begin
               s_in = byte_sum;
            end
            byte_in = byte_ff + 5'd1;
         end
         gbn_pkg::CMD_SEND: begin
            rsp_load = 1'b1;
            rsp_in   = '{result_kind: gbn_pkg::KIND_SENT, packet_sequence: next_ff,
                         packet_check: s_ff[31:0], out_payload_low: low_ff,
                         out_payload_middle: middle_ff, out_payload_high: high_ff,
                         window_start: base_ff, last_of_run: 1'b1};
            next_in      = next_ff + 32'd1;
            next_slot_in = slot_step(next_ff, next_slot_ff);
            if (outstanding == '0) begin
               timer_run_in = 1'b1;
               timer_cnt_in = '0;
            end
         end
         gbn_pkg::CMD_REFUSE: begin
            rsp_load = 1'b1;
            rsp_in   = '{result_kind: gbn_pkg::KIND_REFUSED, packet_sequence: '0,
                         packet_check: '0, out_payload_low: '0, out_payload_middle: '0,
                         out_payload_high: '0, window_start: base_ff, last_of_run: 1'b1};
         end
         gbn_pkg::CMD_ADVANCE: begin
            base_in      = base_ff + 32'd1;
            base_slot_in = slot_step(base_ff, base_slot_ff);
         end
         gbn_pkg::CMD_ACK_EMIT: begin
            rsp_load = 1'b1;
            rsp_in   = '{result_kind: ack_good ? gbn_pkg::KIND_ACK_OK : gbn_pkg::KIND_ACK_BAD,
                         packet_sequence: ack_term_ff, packet_check: s_ff[31:0],
                         out_payload_low: '0, out_payload_middle: '0,
                         out_payload_high: '0, window_start: base_ff, last_of_run: 1'b1};
            if (ack_good && in_window_ff) begin
               timer_cnt_in = '0;
               timer_run_in = base_ff != next_ff;
            end
         end
         gbn_pkg::CMD_TICK: begin
            retx_cnt_in  = '0;
            retx_slot_in = base_slot_ff;
            if (timer_run_ff) begin
               if (tick_expire) begin
                  timer_cnt_in = '0;
                  timer_run_in = outstanding != '0;
               end else begin
                  timer_cnt_in = tick_cnt;
               end
            end
         end
         gbn_pkg::CMD_RETX: begin
            rsp_load = 1'b1;
            rsp_in   = '{result_kind: gbn_pkg::KIND_RETX,
                         packet_sequence: base_ff + 32'(retx_cnt_ff),
                         packet_check: rd_entry_ff.check, out_payload_low: rd_entry_ff.low,
                         out_payload_middle: rd_entry_ff.middle,
                         out_payload_high: rd_entry_ff.high, window_start: base_ff,
                         last_of_run: status.retx_last};
            retx_cnt_in  = retx_cnt_ff + 1'b1;
            retx_slot_in = slot_step(base_ff + 32'(retx_cnt_ff), retx_slot_ff);
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_comb begin
      status.op           = op_ff;
      status.window_full  = outstanding >= WINDOW_32;
      status.fold_busy    = fold_busy;
      status.bytes_last   = byte_ff == BYTE_LAST;
      status.ack_good     = ack_good;
      status.advance      = ack_good && in_window_ff;
      status.advance_more = base_ff != nb_ff;
      status.expire       = tick_expire && (outstanding != '0);
      status.retx_last    = (32'(retx_cnt_ff) + 32'd1) == outstanding;
      status.out_free     = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_ff      <= '0;
         base_slot_ff <= '0;
         next_slot_ff <= '0;
         timer_run_ff <= 1'b0;
         timer_cnt_ff <= '0;
         timeout_ff   <= gbn_pkg::DEFAULT_TIMEOUT;
         rsp_valid_ff <= 1'b0;
         op_ff        <= gbn_pkg::OP_NONE;
         retx_cnt_ff  <= '0;
      end else begin
         base_ff      <= base_in;
         next_ff      <= next_in;
         base_slot_ff <= base_slot_in;
         next_slot_ff <= next_slot_in;
         timer_run_ff <= timer_run_in;
         timer_cnt_ff <= timer_cnt_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         retx_cnt_ff  <= retx_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      middle_ff    <= middle_in;
      high_ff      <= high_in;
      seq_term_ff  <= seq_term_in;
      ack_term_ff  <= ack_term_in;
      ack_check_ff <= ack_check_in;
      nb_ff        <= nb_in;
      in_window_ff <= in_window_in;
      s_ff         <= s_in;
      byte_ff      <= byte_in;
      retx_slot_ff <= retx_slot_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.code == gbn_pkg::CMD_SEND) begin
         mem[next_slot_ff] <= '{low: low_ff, middle: middle_ff, high: high_ff,
                                check: s_ff[31:0]};
      end
      if (cmd.code == gbn_pkg::CMD_READ) begin
         rd_entry_ff <= mem[retx_slot_ff];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding <= WINDOW_32)
      else $error("Outstanding packets exceed the window.");

   a_stopped_timer_clear: assert property (@(posedge clock) disable iff (reset)
      !timer_run_ff |-> (timer_cnt_ff == '0))
      else $error("Stopped retransmit timer holds a nonzero count.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("Result register loaded while holding an untaken result.");

endmodule

[hw/rtl/gbn_ctrl.sv]
// Controller state machine of the Go-Back-N sender.
module gbn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gbn_pkg::status_type status,
   output gbn_pkg::cmd_type    cmd
);

   gbn_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbn_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.code  = gbn_pkg::CMD_IDLE;
      req_ready = 1'b0;
      unique case (state_ff)
         gbn_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.code = gbn_pkg::CMD_LOAD;
               state_in = gbn_pkg::S_DECODE;
            end
         end
         gbn_pkg::S_DECODE: begin
            unique case (status.op)
               gbn_pkg::OP_SEND: begin
                  if (status.window_full) begin
                     state_in = gbn_pkg::S_REFUSE;
                  end else begin
                     cmd.code = gbn_pkg::CMD_FOLD_SEQ;
                     state_in = gbn_pkg::S_FOLD1;
                  end
               end
               gbn_pkg::OP_ACK: begin
                  cmd.code = gbn_pkg::CMD_FOLD_SEQ;
                  state_in = gbn_pkg::S_FOLD1;
               end
               gbn_pkg::OP_TICK: begin
                  cmd.code = gbn_pkg::CMD_TICK;
                  state_in = status.expire ? gbn_pkg::S_READ : gbn_pkg::S_IDLE;
               end
               default: begin
                  state_in = gbn_pkg::S_IDLE;
               end
            endcase
         end
         gbn_pkg::S_REFUSE: begin
            if (status.out_free) begin
               cmd.code = gbn_pkg::CMD_REFUSE;
               state_in = gbn_pkg::S_IDLE;
            end
         end
         gbn_pkg::S_FOLD1: begin
            if (!status.fold_busy) begin
               cmd.code = gbn_pkg::CMD_FOLD_ACK;
               state_in = gbn_pkg::S_FOLD2;
            end
         end
         gbn_pkg::S_FOLD2: begin
            if (!status.fold_busy) begin
               cmd.code = gbn_pkg::CMD_CAPTURE;
               state_in = gbn_pkg::S_BYTES;
            end
         end
         gbn_pkg::S_BYTES: begin
            cmd.code = gbn_pkg::CMD_BYTE;
            if (status.bytes_last) begin
               state_in = gbn_pkg::S_FINISH;
            end
         end
         gbn_pkg::S_FINISH: begin
            if (status.op == gbn_pkg::OP_ACK && status.advance) begin
               state_in = gbn_pkg::S_ADVANCE;
            end else if (status.out_free) begin
               cmd.code = (status.op == gbn_pkg::OP_SEND) ? gbn_pkg::CMD_SEND
                                                         : gbn_pkg::CMD_ACK_EMIT;
               state_in = gbn_pkg::S_IDLE;
            end
         end
         gbn_pkg::S_ADVANCE: begin
            if (status.advance_more) begin
               cmd.code = gbn_pkg::CMD_ADVANCE;
            end else if (status.out_free) begin
               cmd.code = gbn_pkg::CMD_ACK_EMIT;
               state_in = gbn_pkg::S_IDLE;
            end
         end
         gbn_pkg::S_READ: begin
            cmd.code = gbn_pkg::CMD_READ;
            state_in = gbn_pkg::S_RETX;
         end
         gbn_pkg::S_RETX: begin
            if (status.out_free) begin
               cmd.code = gbn_pkg::CMD_RETX;
               state_in = status.retx_last ? gbn_pkg::S_IDLE : gbn_pkg::S_READ;
            end
         end
         default: begin
            state_in = gbn_pkg::S_IDLE;
         end
      endcase
   end

endmodule
